// ----- rtl/tcce_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the text console character engine.
// Used by the engine core; depends on nothing else.

package tcce_pkg;

  // Screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COLX_W = COL_W + 1;
  localparam int ROWX_W = ROW_W + 1;

  // Field widths of the channel payloads
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int CLR_W  = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOUR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOUR = 2'd1;

  localparam logic [CLR_W-1:0] BACK_RESET = 4'h0;
  localparam logic [CLR_W-1:0] FORE_RESET = 4'hF;

  // Cell and character codes
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_FIRST   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST    = 8'h7F;

  typedef enum logic [1:0] {
    CMD_PUT,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } tcce_cmd_t;

  typedef struct packed {
    tcce_cmd_t         cmd;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  cell_index;
  } tcce_in_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } tcce_out_t;

endpackage

// ----- rtl/text_console_char_engine_core.sv -----
`timescale 1ns / 1ps
// Text console character engine: cursor logic, buffer sequencer, channels.
// Depends on tcce_pkg and tcce_ram.

// The screen buffer (COLUMNS x ROWS cells of 16 bits) lives in a single
// RAM with one write and one registered read port. After reset the block
// blanks the buffer one cell per cycle and holds in_stall high until that
// pass is done; configuration writes are taken during that pass. A put
// that scrolls copies rows 1..ROWS-1 up one cell per cycle and then blanks
// the last row; clear blanks the whole buffer. One item is in work at a
// time; the finished result sits in an output register, so the next item
// can be taken while it waits on out_stall.

module text_console_char_engine_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tcce_pkg::tcce_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tcce_pkg::tcce_out_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_BLANK,
    S_CLEAR,
    S_DONE
  } state_t;

  state_t                              state_r;
  logic [tcce_pkg::ADDR_W-1:0]         sweep_r;
  logic                                copy_vld_r;
  logic [tcce_pkg::ADDR_W-1:0]         copy_waddr_r;
  logic [tcce_pkg::COL_W-1:0]          cursor_col_r;
  logic [tcce_pkg::ROW_W-1:0]          cursor_row_r;
  logic [tcce_pkg::CLR_W-1:0]          back_colour_r;
  logic [tcce_pkg::CLR_W-1:0]          fore_colour_r;
  logic [tcce_pkg::POS_W-1:0]          res_pos_r;
  logic [tcce_pkg::CELL_W-1:0]         res_data_r;
  logic                                res_scr_r;
  logic                                out_valid_r;
  tcce_pkg::tcce_out_t                 out_data_r;

  logic                                in_acc;
  logic                                out_free;
  logic                                sweep_last;
  logic                                read_in_range;

  // Put path
  logic [tcce_pkg::COLX_W-1:0]         col_n;
  logic [tcce_pkg::ROWX_W-1:0]         row_n;
  logic                                write_char;
  logic                                need_scroll;
  logic [tcce_pkg::ROWX_W-1:0]         row_fin;
  logic [tcce_pkg::COL_W-1:0]          col_fin;
  logic [tcce_pkg::ADDR_W-1:0]         cur_lin;
  logic [tcce_pkg::ADDR_W-1:0]         put_lin;

  // RAM ports
  logic                                ram_we;
  logic [tcce_pkg::ADDR_W-1:0]         ram_waddr;
  logic [tcce_pkg::CELL_W-1:0]         ram_wdata;
  logic                                ram_re;
  logic [tcce_pkg::ADDR_W-1:0]         ram_raddr;
  logic [tcce_pkg::CELL_W-1:0]         ram_rdata;

  assign in_stall      = (state_r != S_IDLE);
  assign in_acc        = in_valid && !in_stall;
  assign out_free      = !out_valid_r || !out_stall;
  assign sweep_last    = (32'(sweep_r) == tcce_pkg::CELLS - 1);
  assign read_in_range = (32'(in_data.cell_index) < tcce_pkg::CELLS);

  // Cursor movement for a put
  always_comb begin
    col_n      = {1'b0, cursor_col_r};
    row_n      = {1'b0, cursor_row_r};
    write_char = 1'b0;
    priority if (in_data.char_code == tcce_pkg::CH_BS) begin
      if (cursor_col_r != '0) begin
        col_n = col_n - tcce_pkg::COLX_W'(1);
      end
    end else if (in_data.char_code == tcce_pkg::CH_TAB) begin
      // Smallest stop past the cursor; no stop left means wrap
      col_n = tcce_pkg::COLX_W'(tcce_pkg::COLUMNS);
      for (int k = (tcce_pkg::COLUMNS - 1) / tcce_pkg::TAB_WIDTH; k >= 1; k--) begin
        if (k * tcce_pkg::TAB_WIDTH > 32'(cursor_col_r)) begin
          col_n = tcce_pkg::COLX_W'(k * tcce_pkg::TAB_WIDTH);
        end
      end
    end else if (in_data.char_code == tcce_pkg::CH_CR) begin
      col_n = '0;
    end else if (in_data.char_code == tcce_pkg::CH_LF) begin
      col_n = '0;
      row_n = row_n + tcce_pkg::ROWX_W'(1);
    end else if (in_data.char_code >= tcce_pkg::CH_FIRST &&
                 in_data.char_code <= tcce_pkg::CH_LAST) begin
      write_char = 1'b1;
      col_n      = col_n + tcce_pkg::COLX_W'(1);
    end else begin
      col_n = {1'b0, cursor_col_r};
    end
    if (32'(col_n) >= tcce_pkg::COLUMNS) begin
      col_n = '0;
      row_n = row_n + tcce_pkg::ROWX_W'(1);
    end
    need_scroll = (32'(row_n) >= tcce_pkg::ROWS);
    row_fin     = need_scroll ? tcce_pkg::ROWX_W'(tcce_pkg::ROWS - 1) : row_n;
    col_fin     = col_n[tcce_pkg::COL_W-1:0];
  end

  assign cur_lin = tcce_pkg::ADDR_W'(tcce_pkg::ADDR_W'(cursor_row_r) *
                   tcce_pkg::ADDR_W'(tcce_pkg::COLUMNS) + tcce_pkg::ADDR_W'(cursor_col_r));
  assign put_lin = tcce_pkg::ADDR_W'(tcce_pkg::ADDR_W'(row_fin) *
                   tcce_pkg::ADDR_W'(tcce_pkg::COLUMNS) + tcce_pkg::ADDR_W'(col_fin));

  // Buffer write: character, then pending copy, then blanking sweep
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_r;
    ram_wdata = tcce_pkg::BLANK_CELL;
    priority if (in_acc && in_data.cmd == tcce_pkg::CMD_PUT && write_char) begin
      ram_we    = 1'b1;
      ram_waddr = cur_lin;
      ram_wdata = {back_colour_r, fore_colour_r, in_data.char_code};
    end else if (copy_vld_r) begin
      ram_we    = 1'b1;
      ram_waddr = copy_waddr_r;
      ram_wdata = ram_rdata;
    end else if (state_r == S_INIT || state_r == S_CLEAR || state_r == S_BLANK) begin
      ram_we = 1'b1;
    end else begin
      ram_we = 1'b0;
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = sweep_r;
    priority if (in_acc && in_data.cmd == tcce_pkg::CMD_READ && read_in_range) begin
      ram_re    = 1'b1;
      ram_raddr = tcce_pkg::ADDR_W'(in_data.cell_index);
    end else if (state_r == S_SCROLL) begin
      ram_re = 1'b1;
    end else begin
      ram_re = 1'b0;
    end
  end

  tcce_ram #(
    .DEPTH (tcce_pkg::CELLS),
    .WIDTH (tcce_pkg::CELL_W)
  ) u_buf (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      back_colour_r <= tcce_pkg::BACK_RESET;
      fore_colour_r <= tcce_pkg::FORE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tcce_pkg::REG_BACK_COLOUR: back_colour_r <= cfg_wdata[tcce_pkg::CLR_W-1:0];
        tcce_pkg::REG_FORE_COLOUR: fore_colour_r <= cfg_wdata[tcce_pkg::CLR_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, cursor and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      sweep_r      <= '0;
      copy_vld_r   <= 1'b0;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      copy_vld_r <= (state_r == S_SCROLL);
      if (out_free) begin
        out_valid_r <= (state_r == S_DONE);
      end
      unique case (state_r)
        S_INIT: begin
          if (sweep_last) begin
            state_r <= S_IDLE;
          end else begin
            sweep_r <= sweep_r + tcce_pkg::ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_data.cmd)
              tcce_pkg::CMD_PUT: begin
                cursor_col_r <= col_fin;
                cursor_row_r <= row_fin[tcce_pkg::ROW_W-1:0];
                res_pos_r    <= tcce_pkg::POS_W'(put_lin);
                res_data_r   <= '0;
                res_scr_r    <= need_scroll;
                if (need_scroll) begin
                  sweep_r <= tcce_pkg::ADDR_W'(tcce_pkg::COLUMNS);
                  state_r <= S_SCROLL;
                end else begin
                  state_r <= S_DONE;
                end
              end
              tcce_pkg::CMD_CLEAR: begin
                cursor_col_r <= '0;
                cursor_row_r <= '0;
                res_pos_r    <= '0;
                res_data_r   <= '0;
                res_scr_r    <= 1'b0;
                sweep_r      <= '0;
                state_r      <= S_CLEAR;
              end
              tcce_pkg::CMD_READ: begin
                res_pos_r  <= tcce_pkg::POS_W'(cur_lin);
                res_data_r <= '0;
                res_scr_r  <= 1'b0;
                state_r    <= read_in_range ? S_READ : S_DONE;
              end
              tcce_pkg::CMD_NOP: begin
                res_pos_r  <= tcce_pkg::POS_W'(cur_lin);
                res_data_r <= '0;
                res_scr_r  <= 1'b0;
                state_r    <= S_DONE;
              end
              default: begin
                res_pos_r  <= tcce_pkg::POS_W'(cur_lin);
                res_data_r <= '0;
                res_scr_r  <= 1'b0;
                state_r    <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          res_data_r <= ram_rdata;
          state_r    <= S_DONE;
        end
        S_SCROLL: begin
          // Read one row ahead; the copy is written in the following cycle
          copy_waddr_r <= sweep_r - tcce_pkg::ADDR_W'(tcce_pkg::COLUMNS);
          if (sweep_last) begin
            sweep_r <= tcce_pkg::ADDR_W'((tcce_pkg::ROWS - 1) * tcce_pkg::COLUMNS);
            state_r <= S_BLANK;
          end else begin
            sweep_r <= sweep_r + tcce_pkg::ADDR_W'(1);
          end
        end
        S_BLANK: begin
          // Hold while the last copy drains through the write port
          if (!copy_vld_r) begin
            if (sweep_last) begin
              state_r <= S_DONE;
            end else begin
              sweep_r <= sweep_r + tcce_pkg::ADDR_W'(1);
            end
          end
        end
        S_CLEAR: begin
          if (sweep_last) begin
            state_r <= S_DONE;
          end else begin
            sweep_r <= sweep_r + tcce_pkg::ADDR_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_r.cursor_pos <= res_pos_r;
            out_data_r.cell_data  <= res_data_r;
            out_data_r.scrolled   <= res_scr_r;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_INIT;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cursor_row_r) < tcce_pkg::ROWS)
    else $error("cursor row past last row");

  a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.scrolled |->
      32'(out_data_r.cursor_pos) >= (tcce_pkg::ROWS - 1) * tcce_pkg::COLUMNS)
    else $error("scrolled result with cursor above last row");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  a_copy_from_scroll: assert property (@(posedge clk) disable iff (!rst_n)
    copy_vld_r |-> $past(state_r == S_SCROLL) && !(state_r == S_IDLE))
    else $error("row copy write outside scroll");
`endif

endmodule

// ----- rtl/tcce_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port with registered data.
// Generic; no package dependency.

module tcce_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
